// ===== design/ebb_pkg.sv =====
// Package for the endian byte buffer engine: store size, op and status codes,
// sequencer states and the capacity clamp. No dependencies.
package ebb_pkg;

  localparam int MAX_BYTES = 32768;
  localparam int ADDR_W    = $clog2(MAX_BYTES);
  localparam int CAP_TOP   = (MAX_BYTES > 65535) ? 65535 : MAX_BYTES;

  localparam logic [15:0] CAPACITY_RESET = 16'd28;
  localparam logic [15:0] CAPACITY_FLOOR = 16'd4;
  localparam logic [15:0] CAPACITY_TOP   = CAP_TOP[15:0];

  localparam logic [1:0] OP_APPEND  = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_SET_LEN = 2'd2;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_NO_ROOM  = 3'd1;
  localparam logic [2:0] STAT_BAD_SIZE = 3'd2;
  localparam logic [2:0] STAT_RANGE    = 3'd3;
  localparam logic [2:0] STAT_ZERO     = 3'd4;

  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_FILL,
    ST_DONE
  } state_t;

  function automatic logic [15:0] eff_cap(input logic [15:0] c);
    logic [15:0] r;
    r = c;
    if (c < CAPACITY_FLOOR) r = CAPACITY_FLOOR;
    if (c > CAPACITY_TOP) r = CAPACITY_TOP;
    return r;
  endfunction

endpackage

// ===== design/endian_byte_buffer_engine.sv =====
// Endian byte buffer engine: a byte-wide synchronous store with a fill length,
// endian pack on append, unpack on read, and zero-fill on length growth.
// Depends on ebb_pkg.
//
// One item is taken at a time. An append or a read moves one byte per cycle
// through the single byte-wide write port or the registered read port of the
// store, and a set-length that grows the fill writes one zeroed byte per cycle
// from the old length up to the new length, clamped to the capacity. The store
// needs no clearing after reset. A finished result waits in the output
// register while the next item is accepted.
module endian_byte_buffer_engine import ebb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  op,
  input  logic [2:0]  byte_count,
  input  logic        big_endian,
  input  logic [31:0] write_value,
  input  logic [15:0] offset,
  input  logic [15:0] new_length,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] read_value,
  output logic [15:0] fill_length,
  output logic [2:0]  status
);

  logic [7:0] byte_store [MAX_BYTES];

  state_t      state;
  state_t      state_next;
  logic [15:0] capacity;
  logic [15:0] length;
  logic [1:0]  last_idx;
  logic        big;
  logic [31:0] wval;
  logic [15:0] base;
  logic [15:0] target;
  logic [1:0]  cnt;
  logic        issue_done;
  logic        rd_vld;
  logic [1:0]  rd_idx;
  logic [7:0]  rd_data;
  logic [15:0] fill_ptr;
  logic [31:0] acc;
  logic [2:0]  res_status;

  logic              cfg_wr;
  logic [15:0]       cap;
  logic              accept;
  logic              size_ok;
  logic [16:0]       size_ext;
  logic              room_ok;
  logic              span_ok;
  logic [15:0]       target_d;
  logic              go_write;
  logic              go_read;
  logic              go_fill;
  logic [2:0]        status_d;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic              issuing;
  logic              last_data;
  logic              load_out;

  function automatic logic [1:0] lane(input logic [1:0] i, input logic b,
                                      input logic [1:0] last);
    return b ? 2'(last - i) : i;
  endfunction

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_CAPACITY) ? {16'd0, capacity} : 32'd0;
  assign cap    = eff_cap(capacity);

  assign accept   = item_valid && !item_stall;
  assign size_ext = {14'd0, byte_count};
  assign room_ok  = ({1'b0, length} + size_ext) <= {1'b0, cap};
  assign span_ok  = ({1'b0, offset} + size_ext) <= {1'b0, length};
  assign target_d = (new_length > cap) ? cap : new_length;

  always_comb begin
    case (byte_count) inside
      3'd1, 3'd2, 3'd4: size_ok = 1'b1;
      default:          size_ok = 1'b0;
    endcase
  end

  always_comb begin
    go_write = 1'b0;
    go_read  = 1'b0;
    go_fill  = 1'b0;
    status_d = STAT_OK;
    unique case (op)
      OP_APPEND, OP_READ: begin
        if (byte_count == 3'd0) begin
          status_d = STAT_ZERO;
        end else if (!size_ok) begin
          status_d = STAT_BAD_SIZE;
        end else if (op == OP_APPEND) begin
          if (room_ok) go_write = 1'b1;
          else status_d = STAT_NO_ROOM;
        end else begin
          if (span_ok) go_read = 1'b1;
          else status_d = STAT_RANGE;
        end
      end
      OP_SET_LEN: go_fill = target_d > length;
      default: status_d = STAT_OK;
    endcase
  end

  assign last_data = rd_vld && (rd_idx == last_idx);
  assign load_out  = !result_valid || !result_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (go_write) state_next = ST_WRITE;
          else if (go_read) state_next = ST_READ;
          else if (go_fill) state_next = ST_FILL;
          else state_next = ST_DONE;
        end
      end
      ST_WRITE: if (cnt == last_idx) state_next = ST_DONE;
      ST_READ:  if (last_data) state_next = ST_DONE;
      ST_FILL:  if (16'(fill_ptr + 16'd1) == target) state_next = ST_DONE;
      ST_DONE:  if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = 1'b1;
    mem_we     = 1'b0;
    issuing    = 1'b0;
    mem_waddr  = ADDR_W'(length + 16'(cnt));
    mem_wdata  = wval[8*lane(cnt, big, last_idx) +: 8];
    mem_raddr  = ADDR_W'(base + 16'(cnt));
    unique case (state)
      ST_IDLE:  item_stall = 1'b0;
      ST_WRITE: mem_we = 1'b1;
      ST_READ:  issuing = !issue_done;
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_ptr[ADDR_W-1:0];
        mem_wdata = 8'd0;
      end
      ST_DONE:  item_stall = 1'b1;
      default:  item_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) byte_store[mem_waddr] <= mem_wdata;
    rd_data <= byte_store[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      capacity     <= CAPACITY_RESET;
      length       <= 16'd0;
      rd_vld       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issuing;
      if (cfg_wr && paddr[2] == REG_CAPACITY) begin
        capacity <= pwdata[15:0];
        if (length > eff_cap(pwdata[15:0])) length <= eff_cap(pwdata[15:0]);
      end else if (accept && op == OP_SET_LEN && !go_fill) begin
        length <= target_d;
      end else if (state == ST_WRITE && cnt == last_idx) begin
        length <= length + 16'(last_idx) + 16'd1;
      end else if (state == ST_FILL && state_next == ST_DONE) begin
        length <= target;
      end
      if (state == ST_DONE && load_out) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_idx   <= 2'(byte_count - 3'd1);
      big        <= big_endian;
      wval       <= write_value;
      base       <= offset;
      target     <= target_d;
      fill_ptr   <= length;
      cnt        <= 2'd0;
      issue_done <= 1'b0;
      acc        <= 32'd0;
      res_status <= status_d;
    end else begin
      if (state == ST_WRITE || issuing) cnt <= cnt + 2'd1;
      if (issuing && cnt == last_idx) issue_done <= 1'b1;
      if (state == ST_FILL) fill_ptr <= fill_ptr + 16'd1;
      if (rd_vld) acc[8*lane(rd_idx, big, last_idx) +: 8] <= rd_data;
    end
    rd_idx <= cnt;
    if (state == ST_DONE && load_out) begin
      read_value  <= acc;
      fill_length <= length;
      status      <= res_status;
    end
  end

  assert property (@(posedge clk) disable iff (rst) length <= cap)
    else $error("fill length above capacity");

  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_WRITE || state == ST_FILL))
    else $error("store written outside append or fill");

  assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(state) == ST_READ)
    else $error("read data without a read issue");

  assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted beat not processed");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (read_value == 32'd0 || status == STAT_OK))
    else $error("nonzero read value with error status");

endmodule
